// ===== rtl/core/wpc_pkg.sv =====
// shared types, constants and the cordic arctangent table of the waypoint controller
// used by wpc_cordic, wpc_mdu and waypoint_pursuit_controller_top
`default_nettype none

package wpc_pkg;

  localparam int CORDIC_ITERATIONS = 16;

  // cordic datapath widths
  localparam int CW  = 40;
  localparam int ZW  = 34;
  localparam int IXW = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [1:0] MODE_POSE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_WATCH = 2'd2;

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_FOLLOW  = 2'd1;
  localparam logic [1:0] PH_REACHED = 2'd2;

  localparam logic [1:0] CAUSE_DRIVE   = 2'd0;
  localparam logic [1:0] CAUSE_REACHED = 2'd1;
  localparam logic [1:0] CAUSE_LOST    = 2'd2;

  localparam logic [2:0] REG_ANG_GAIN = 3'd0;
  localparam logic [2:0] REG_LIN_GAIN = 3'd1;
  localparam logic [2:0] REG_MAX_LIN  = 3'd2;
  localparam logic [2:0] REG_MAX_ANG  = 3'd3;
  localparam logic [2:0] REG_SLOW     = 3'd4;
  localparam logic [2:0] REG_REACH    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;
  localparam logic [2:0] REG_WP_DIST  = 3'd7;

  localparam logic [23:0]          INV_K_Q24    = 24'd10188014;
  localparam logic signed [CW-1:0] INV_K_Q30    = 40'sd652032874;
  localparam logic [31:0]          PI_Q29       = 32'd1686629713;
  localparam logic signed [16:0]   FACTOR_FLOOR = 17'sd9830;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        time_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_word_t;

  typedef struct packed {
    logic [18:0]        linear_speed;
    logic signed [19:0] angular_speed;
    logic [1:0]         cause;
    logic [1:0]         nav_mode;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  typedef struct packed {
    logic start;
    logic divide;
  } mdu_req_t;

  // atan(2^-i) in 32-bit binary angle units, truncated
  function automatic logic [ZW-1:0] atan_entry(input logic [IXW-1:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'd536870912;
      5'd1:  v = 34'd316933406;
      5'd2:  v = 34'd167458907;
      5'd3:  v = 34'd85004756;
      5'd4:  v = 34'd42667331;
      5'd5:  v = 34'd21354465;
      5'd6:  v = 34'd10679838;
      5'd7:  v = 34'd5340245;
      5'd8:  v = 34'd2670163;
      5'd9:  v = 34'd1335087;
      5'd10: v = 34'd667544;
      5'd11: v = 34'd333772;
      5'd12: v = 34'd166886;
      5'd13: v = 34'd83443;
      5'd14: v = 34'd41721;
      5'd15: v = 34'd20860;
      5'd16: v = 34'd10430;
      5'd17: v = 34'd5215;
      5'd18: v = 34'd2607;
      5'd19: v = 34'd1303;
      5'd20: v = 34'd651;
      5'd21: v = 34'd325;
      5'd22: v = 34'd162;
      5'd23: v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpc_cordic.sv =====
// iterative cordic, one micro-rotation per cycle, vectoring (angle, magnitude) and rotation
// (cos, sin); depends on wpc_pkg
`default_nettype none

module wpc_cordic #(
  parameter int ITER = wpc_pkg::CORDIC_ITERATIONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wpc_pkg::cordic_req_t          req,
  input  wire logic signed [wpc_pkg::CW-1:0] x_in,
  input  wire logic signed [wpc_pkg::CW-1:0] y_in,
  input  wire logic [15:0]                   h_in,
  output logic                               done,
  output logic signed [wpc_pkg::CW-1:0]      x_out,
  output logic signed [wpc_pkg::CW-1:0]      y_out,
  output logic [15:0]                        ang_out
);
  import wpc_pkg::*;

  localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF    = 34'sd2147483648;
  localparam logic signed [ZW-1:0] RND     = 34'sd32768;

  logic signed [CW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, za, zh, zr;
  logic [IXW-1:0]       i;
  logic                 busy, rot, neg, up;

  always_comb begin
    xs = x >>> i;
    ys = y >>> i;
    za = signed'(atan_entry(i));
    up = rot ? z[ZW-1] : (y > 0);
    zh = signed'({{2{h_in[15]}}, h_in, 16'b0});
    zr = z + RND;
  end

  assign x_out   = neg ? -x : x;
  assign y_out   = neg ? -y : y;
  assign ang_out = zr[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rot <= req.rotate;
        i   <= '0;
        if (req.rotate) begin
          x    <= INV_K_Q30;
          y    <= '0;
          busy <= 1'b1;
          // fold the angle into the right half plane, flip the result back
          if (zh > QUARTER) begin
            z   <= zh - HALF;
            neg <= 1'b1;
          end else if (zh < -QUARTER) begin
            z   <= zh + HALF;
            neg <= 1'b1;
          end else begin
            z   <= zh;
            neg <= 1'b0;
          end
        end else begin
          neg <= 1'b0;
          if (x_in == 0 && y_in == 0) begin
            x    <= '0;
            y    <= '0;
            z    <= '0;
            done <= 1'b1;
          end else if (x_in < 0) begin
            x    <= -x_in;
            y    <= -y_in;
            z    <= HALF;
            busy <= 1'b1;
          end else begin
            x    <= x_in;
            y    <= y_in;
            z    <= '0;
            busy <= 1'b1;
          end
        end
      end else if (busy) begin
        if (up) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + za;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - za;
        end
        i <= i + 1'b1;
        if (i == IXW'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpc_mdu.sv =====
// shared multiply/divide unit: signed shift-add multiply (one multiplier bit per cycle)
// and restoring unsigned divide by a 21-bit divisor (one quotient bit per cycle); uses wpc_pkg
`default_nettype none

module wpc_mdu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wpc_pkg::mdu_req_t  req,
  input  wire logic signed [63:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic [63:0]             result
);
  import wpc_pkg::*;

  logic [63:0] acc, mcand, quo;
  logic [31:0] mplier;
  logic [20:0] rem, dvs;
  logic [21:0] rsh, rdiff;
  logic [5:0]  cnt;
  logic        busy, div, fits, last;

  always_comb begin
    rsh   = {rem, quo[63]};
    rdiff = rsh - {1'b0, dvs};
    fits  = rsh >= {1'b0, dvs};
    last  = div ? (cnt == 6'd63) : (cnt == 6'd31);
  end

  assign result = div ? quo : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        div    <= req.divide;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= a;
        mplier <= b;
        quo    <= a;
        rem    <= '0;
        dvs    <= b[20:0];
      end else if (busy) begin
        if (div) begin
          quo <= {quo[62:0], fits};
          rem <= fits ? rdiff[20:0] : rsh[20:0];
        end else begin
          // top multiplier bit carries negative weight
          if (mplier[0]) acc <= (cnt == 6'd31) ? acc - mcand : acc + mcand;
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
        end
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/waypoint_pursuit_controller_top.sv =====
// Waypoint pursuit controller for a differential-drive car. One word is taken at a time:
// in_stall is high from acceptance until the word is finished. In the sequencer a pose word
// runs four multiplies and a cordic vectoring pass, and the first pose adds a rotation pass
// and two multiplies. A control tick runs a vectoring pass, the distance multiply, two gain
// multiplies and two speed multiplies, with one more multiply and the divide inside the
// slow-down radius; on arrival it ends after the distance multiply. A watchdog tick, an
// ignored word and a tick while not following use neither unit.
// A word that ends with a result also waits while the output register is full and stalled.
// The multiply/divide unit is shared and bit-serial. A finished result sits in an output
// register, so the next word is taken while it waits.
// depends on wpc_pkg, wpc_cordic, wpc_mdu
`default_nettype none

module waypoint_pursuit_controller_top #(
  parameter int ITER = wpc_pkg::CORDIC_ITERATIONS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire wpc_pkg::in_word_t                 in_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output wpc_pkg::out_word_t                     out_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wpc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_QM0  = 5'd2;
  localparam logic [4:0] S_QM1  = 5'd3;
  localparam logic [4:0] S_QM2  = 5'd4;
  localparam logic [4:0] S_QM3  = 5'd5;
  localparam logic [4:0] S_QVEC = 5'd6;
  localparam logic [4:0] S_ROT  = 5'd7;
  localparam logic [4:0] S_TX   = 5'd8;
  localparam logic [4:0] S_TY   = 5'd9;
  localparam logic [4:0] S_CVEC = 5'd10;
  localparam logic [4:0] S_DIST = 5'd11;
  localparam logic [4:0] S_CHK  = 5'd12;
  localparam logic [4:0] S_G1   = 5'd13;
  localparam logic [4:0] S_G2   = 5'd14;
  localparam logic [4:0] S_L1   = 5'd15;
  localparam logic [4:0] S_L2   = 5'd16;
  localparam logic [4:0] S_L3   = 5'd17;
  localparam logic [4:0] S_L4   = 5'd18;
  localparam logic [4:0] S_EMIT = 5'd19;

  localparam logic [63:0] Q28_MAX = 64'h0000_0100_0000_0000;

  // configuration
  logic [15:0] ang_gain, lin_gain, timeout_ms;
  logic [18:0] max_lin, max_ang;
  logic [20:0] slow_dist, arrive_rad, wp_dist;

  // navigation state
  logic [4:0]         state;
  logic               pend;
  logic [1:0]         phase;
  logic signed [31:0] cur_x, cur_y, tgt_x, tgt_y;
  logic [15:0]        cur_h, tgt_ang;
  logic [31:0]        last_ms;

  // work registers
  in_word_t             in_r;
  logic signed [CW-1:0] vx, vy;
  logic signed [63:0]   t0;
  logic [35:0]          gap;
  logic [63:0]          q28;
  logic [18:0]          res_lin;
  logic signed [19:0]   res_ang;
  logic [1:0]           res_cause;

  // unit connections
  cordic_req_t          cord_req;
  mdu_req_t             mdu_req;
  logic                 cord_done, mdu_done, use_cord, use_mdu;
  logic signed [CW-1:0] cord_xi, cord_yi, cord_x, cord_y;
  logic [15:0]          cord_ang;
  logic signed [63:0]   mdu_a, prod;
  logic signed [31:0]   mdu_b;
  logic [63:0]          mdu_res;

  // datapath
  logic signed [15:0] err;
  logic signed [16:0] err17, aerr, fac_raw, fac;
  logic signed [CW-1:0] dx, dy;
  logic signed [63:0] off_r, pos_sel, tsum, dist_r, ang_r;
  logic [63:0]        lin_r, q28_sat;
  logic signed [31:0] tsat;
  logic signed [23:0] ang24, lim24, ang_clamp;
  logic [18:0]        lin_clamp;
  logic [31:0]        since;
  logic               emit_go;

  wpc_cordic #(.ITER(ITER)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (cord_req),
    .x_in    (cord_xi),
    .y_in    (cord_yi),
    .h_in    (cur_h),
    .done    (cord_done),
    .x_out   (cord_x),
    .y_out   (cord_y),
    .ang_out (cord_ang)
  );

  wpc_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mdu_req),
    .a      (mdu_a),
    .b      (mdu_b),
    .done   (mdu_done),
    .result (mdu_res)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign prod      = signed'(mdu_res);
  assign emit_go   = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    err     = signed'(tgt_ang - cur_h);
    err17   = {err[15], err};
    aerr    = err17[16] ? -err17 : err17;
    fac_raw = 17'sd32768 - aerr;
    fac     = (fac_raw < FACTOR_FLOOR) ? FACTOR_FLOOR : fac_raw;
    dx      = CW'(signed'({tgt_x[31], tgt_x}) - signed'({cur_x[31], cur_x}));
    dy      = CW'(signed'({tgt_y[31], tgt_y}) - signed'({cur_y[31], cur_y}));
    q28_sat = (q28 > Q28_MAX) ? Q28_MAX : q28;
    since   = in_r.time_ms - last_ms;

    // rounding of the multiply results
    off_r   = (prod + 64'sd536870912) >>> 30;
    pos_sel = (state == S_TY) ? 64'(in_r.pos_y) : 64'(in_r.pos_x);
    tsum    = pos_sel + off_r;
    if (tsum > 64'sd2147483647)       tsat = 32'sh7FFF_FFFF;
    else if (tsum < -64'sd2147483648) tsat = 32'sh8000_0000;
    else                              tsat = tsum[31:0];
    dist_r  = (prod + 64'sd8388608) >>> 24;
    ang_r   = (prod + 64'sd549755813888) >>> 40;
    ang24   = ang_r[23:0];
    lim24   = signed'({5'b0, max_ang});
    if (ang24 > lim24)       ang_clamp = lim24;
    else if (ang24 < -lim24) ang_clamp = -lim24;
    else                     ang_clamp = ang24;
    lin_r   = (mdu_res + 64'd67108864) >> 27;
    lin_clamp = (lin_r > {45'b0, max_lin}) ? max_lin : lin_r[18:0];
  end

  // unit selection and operands
  always_comb begin
    use_cord = 1'b0;
    use_mdu  = 1'b0;
    cord_req.rotate = 1'b0;
    mdu_req.divide  = 1'b0;
    cord_xi  = vx;
    cord_yi  = vy;
    mdu_a    = '0;
    mdu_b    = '0;
    unique case (state)
      S_QM0: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(in_r.quat_x);
        mdu_b   = 32'(in_r.quat_z);
      end
      S_QM1: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(in_r.quat_w);
        mdu_b   = 32'(in_r.quat_y);
      end
      S_QM2: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(in_r.quat_y);
        mdu_b   = 32'(in_r.quat_z);
      end
      S_QM3: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(in_r.quat_w);
        mdu_b   = 32'(in_r.quat_x);
      end
      S_QVEC: use_cord = 1'b1;
      S_ROT: begin
        use_cord        = 1'b1;
        cord_req.rotate = 1'b1;
      end
      S_TX: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(cord_x);
        mdu_b   = signed'({11'b0, wp_dist});
      end
      S_TY: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(cord_y);
        mdu_b   = signed'({11'b0, wp_dist});
      end
      S_CVEC: begin
        use_cord = 1'b1;
        cord_xi  = dx;
        cord_yi  = dy;
      end
      S_DIST: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(cord_x);
        mdu_b   = signed'({8'b0, INV_K_Q24});
      end
      S_G1: begin
        use_mdu = 1'b1;
        mdu_a   = 64'(err);
        mdu_b   = signed'({16'b0, ang_gain});
      end
      S_G2: begin
        use_mdu = 1'b1;
        mdu_a   = t0;
        mdu_b   = signed'(PI_Q29);
      end
      S_L1: begin
        use_mdu = 1'b1;
        mdu_a   = signed'({28'b0, gap});
        mdu_b   = signed'({16'b0, lin_gain});
      end
      S_L2: begin
        use_mdu = 1'b1;
        mdu_a   = signed'(q28);
        mdu_b   = signed'(gap[31:0]);
      end
      S_L3: begin
        use_mdu        = 1'b1;
        mdu_req.divide = 1'b1;
        mdu_a          = t0;
        mdu_b          = signed'({11'b0, slow_dist});
      end
      S_L4: begin
        use_mdu = 1'b1;
        mdu_a   = signed'(q28_sat);
        mdu_b   = 32'(fac);
      end
      default: ;
    endcase
    cord_req.start = use_cord && !pend;
    mdu_req.start  = use_mdu && !pend;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ang_gain   <= 16'd3277;
      lin_gain   <= 16'd2458;
      max_lin    <= 19'd26214;
      max_ang    <= 19'd26214;
      slow_dist  <= 21'd19661;
      arrive_rad <= 21'd9830;
      timeout_ms <= 16'd1000;
      wp_dist    <= 21'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ANG_GAIN: ang_gain   <= cfg_data[15:0];
        REG_LIN_GAIN: lin_gain   <= cfg_data[15:0];
        REG_MAX_LIN:  max_lin    <= cfg_data[18:0];
        REG_MAX_ANG:  max_ang    <= cfg_data[18:0];
        REG_SLOW:     slow_dist  <= cfg_data;
        REG_REACH:    arrive_rad <= cfg_data;
        REG_TIMEOUT:  timeout_ms <= cfg_data[15:0];
        REG_WP_DIST:  wp_dist    <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= 1'b0;
      phase   <= PH_WAIT;
      cur_x   <= '0;
      cur_y   <= '0;
      cur_h   <= '0;
      tgt_x   <= '0;
      tgt_y   <= '0;
      last_ms <= '0;
    end else begin
      if (cord_req.start || mdu_req.start) pend <= 1'b1;
      if (cord_done || mdu_done) pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_r  <= in_word;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_lin   <= '0;
          res_ang   <= '0;
          res_cause <= CAUSE_LOST;
          unique case (in_r.mode)
            MODE_POSE:  state <= S_QM0;
            MODE_TICK:  state <= (phase == PH_FOLLOW) ? S_CVEC : S_IDLE;
            MODE_WATCH: begin
              // a time earlier than the last pose reads as a long silence
              if (phase == PH_FOLLOW && since > {16'b0, timeout_ms}) state <= S_EMIT;
              else state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_QM0: if (mdu_done) begin
          t0    <= prod;
          state <= S_QM1;
        end
        S_QM1: if (mdu_done) begin
          vx    <= CW'(t0 + prod);
          state <= S_QM2;
        end
        S_QM2: if (mdu_done) begin
          t0    <= prod;
          state <= S_QM3;
        end
        S_QM3: if (mdu_done) begin
          vy    <= CW'(t0 - prod);
          state <= S_QVEC;
        end
        S_QVEC: if (cord_done) begin
          cur_h   <= cord_ang;
          cur_x   <= in_r.pos_x;
          cur_y   <= in_r.pos_y;
          last_ms <= in_r.time_ms;
          state   <= (phase == PH_WAIT) ? S_ROT : S_IDLE;
        end
        S_ROT: if (cord_done) state <= S_TX;
        S_TX: if (mdu_done) begin
          tgt_x <= tsat;
          state <= S_TY;
        end
        S_TY: if (mdu_done) begin
          tgt_y <= tsat;
          phase <= PH_FOLLOW;
          state <= S_IDLE;
        end
        S_CVEC: if (cord_done) begin
          tgt_ang <= cord_ang;
          state   <= S_DIST;
        end
        S_DIST: if (mdu_done) begin
          gap   <= dist_r[35:0];
          state <= S_CHK;
        end
        S_CHK: begin
          if (gap < {15'b0, arrive_rad}) begin
            res_cause <= CAUSE_REACHED;
            phase     <= PH_REACHED;
            state     <= S_EMIT;
          end else begin
            state <= S_G1;
          end
        end
        S_G1: if (mdu_done) begin
          t0    <= prod;
          state <= S_G2;
        end
        S_G2: if (mdu_done) begin
          res_ang <= ang_clamp[19:0];
          state   <= S_L1;
        end
        S_L1: if (mdu_done) begin
          q28   <= mdu_res;
          state <= (gap < {15'b0, slow_dist}) ? S_L2 : S_L4;
        end
        S_L2: if (mdu_done) begin
          t0    <= prod;
          state <= S_L3;
        end
        S_L3: if (mdu_done) begin
          q28   <= mdu_res;
          state <= S_L4;
        end
        S_L4: if (mdu_done) begin
          res_lin   <= lin_clamp;
          res_cause <= CAUSE_DRIVE;
          state     <= S_EMIT;
        end
        S_EMIT: if (emit_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (emit_go) begin
        out_valid              <= 1'b1;
        out_word.linear_speed  <= res_lin;
        out_word.angular_speed <= res_ang;
        out_word.cause         <= res_cause;
        out_word.nav_mode      <= phase;
      end
    end
  end

endmodule

`default_nettype wire
